>>> rtl/sgtp_pkg.sv
// Shared types, constants and code range table for the glyph tile position core.
`timescale 1ns / 1ps
`default_nettype none
package sgtp_pkg;

  localparam int GLYPH_WIDTH_DEF   = 14;
  localparam int GLYPH_HEIGHT_DEF  = 16;
  localparam int TILES_PER_ROW_DEF = 16;

  // parameters are held in 7 bits (values up to 127)
  localparam int PARAM_W = 7;

  localparam int CODE_W = 16;
  localparam int TILE_W = 13;
  localparam int X_W    = 8;
  localparam int Y_W    = 13;

  localparam logic [TILE_W-1:0] HOLE_TILE = 13'd96;
  localparam logic [X_W-1:0]    MISS_X    = 8'd0;
  localparam logic [Y_W-1:0]    MISS_Y    = 13'd96;
  localparam logic [7:0]        SKIP_LO   = 8'h7f;

  // single-code remaps and the shifted block
  localparam logic [CODE_W-1:0] REMAP_A_IN  = 16'hfa58;
  localparam logic [CODE_W-1:0] REMAP_A_OUT = 16'h878a;
  localparam logic [CODE_W-1:0] REMAP_B_IN  = 16'hfa59;
  localparam logic [CODE_W-1:0] REMAP_B_OUT = 16'h8782;
  localparam logic [CODE_W-1:0] REMAP_C_IN  = 16'hfa4a;
  localparam logic [CODE_W-1:0] REMAP_C_OUT = 16'h8774;
  localparam logic [CODE_W-1:0] REMAP_D_IN  = 16'hfa5b;
  localparam logic [CODE_W-1:0] REMAP_D_OUT = 16'h879a;
  localparam logic [CODE_W-1:0] SHIFT_LO    = 16'hfa5c;
  localparam logic [CODE_W-1:0] SHIFT_HI    = 16'hfa8b;
  localparam logic [CODE_W-1:0] SHIFT_AMT   = 16'h0d1c;

  typedef struct packed {
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] last;
    logic [TILE_W-1:0] tile0;
    logic              skips;
  } code_range_t;

  // tile number plus miss flag handed from decode to position stages
  typedef struct packed {
    logic              miss;
    logic [TILE_W-1:0] tile;
  } tile_word_t;

  localparam int RANGE_COUNT = 51;
  localparam int RANGE_IDX_W = $clog2(RANGE_COUNT);

  // first match in list order wins
  localparam code_range_t RANGES [RANGE_COUNT] = '{
    '{16'h8140, 16'h81fc, 13'd0,    1'b1}, '{16'h824f, 16'h8258, 13'd192,  1'b0},
    '{16'h8260, 16'h8279, 13'd208,  1'b0}, '{16'h8281, 16'h829a, 13'd240,  1'b0},
    '{16'h829f, 16'h82f1, 13'd272,  1'b0}, '{16'h8340, 16'h8396, 13'd368,  1'b1},
    '{16'h839f, 16'h83b6, 13'd464,  1'b0}, '{16'h83bf, 16'h83d6, 13'd496,  1'b0},
    '{16'h8440, 16'h8460, 13'd528,  1'b0}, '{16'h8470, 16'h8491, 13'd576,  1'b1},
    '{16'h849f, 16'h84be, 13'd624,  1'b0}, '{16'h8740, 16'h879c, 13'd656,  1'b1},
    '{16'h889f, 16'h88fc, 13'd752,  1'b0}, '{16'h8740, 16'h87fc, 13'd846,  1'b1},
    '{16'h8840, 16'h88fc, 13'd1034, 1'b1}, '{16'h8940, 16'h89fc, 13'd1222, 1'b1},
    '{16'h8a40, 16'h8afc, 13'd1410, 1'b1}, '{16'h8b40, 16'h8bfc, 13'd1598, 1'b1},
    '{16'h8c40, 16'h8cfc, 13'd1786, 1'b1}, '{16'h8d40, 16'h8dfc, 13'd1974, 1'b1},
    '{16'h8e40, 16'h8efc, 13'd2162, 1'b1}, '{16'h8f40, 16'h8ffc, 13'd2350, 1'b1},
    '{16'h9040, 16'h90fc, 13'd2538, 1'b1}, '{16'h9140, 16'h91fc, 13'd2726, 1'b1},
    '{16'h9240, 16'h92fc, 13'd2914, 1'b1}, '{16'h9340, 16'h93fc, 13'd3102, 1'b1},
    '{16'h9440, 16'h94fc, 13'd3290, 1'b1}, '{16'h9540, 16'h95fc, 13'd3478, 1'b1},
    '{16'h9640, 16'h9672, 13'd3666, 1'b0}, '{16'h969f, 16'h96fc, 13'd3728, 1'b0},
    '{16'h9740, 16'h97fc, 13'd3822, 1'b1}, '{16'h9840, 16'h98fc, 13'd4010, 1'b1},
    '{16'h9940, 16'h99fc, 13'd4198, 1'b1}, '{16'h9a40, 16'h9afc, 13'd4386, 1'b1},
    '{16'h9b40, 16'h9bfc, 13'd4574, 1'b1}, '{16'h9c40, 16'h9cfc, 13'd4762, 1'b1},
    '{16'h9d40, 16'h9dfc, 13'd4950, 1'b1}, '{16'he040, 16'he0fc, 13'd5138, 1'b1},
    '{16'he140, 16'he1fc, 13'd5326, 1'b1}, '{16'he240, 16'he2fc, 13'd5514, 1'b1},
    '{16'he340, 16'he3fc, 13'd5702, 1'b1}, '{16'he440, 16'he4fc, 13'd5890, 1'b1},
    '{16'he540, 16'he5fc, 13'd6078, 1'b1}, '{16'he640, 16'he6fc, 13'd6266, 1'b1},
    '{16'he740, 16'he7fc, 13'd6454, 1'b1}, '{16'he840, 16'he8fc, 13'd6642, 1'b1},
    '{16'he940, 16'he9fc, 13'd6830, 1'b1}, '{16'hea40, 16'hea7e, 13'd7018, 1'b0},
    '{16'hea80, 16'heaa4, 13'd7081, 1'b0}, '{16'hed40, 16'hed6e, 13'd7136, 1'b0},
    '{16'hfa40, 16'hfa57, 13'd7120, 1'b0}
  };

endpackage
`default_nettype wire

>>> rtl/sgtp_decode.sv
// Code remap, range match and tile number stages (four register stages).
`timescale 1ns / 1ps
`default_nettype none
module sgtp_decode (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic [sgtp_pkg::CODE_W-1:0]       char_code,
  output logic                                   tile_valid,
  output sgtp_pkg::tile_word_t                   tile_word
);

  // stage 1: remapped code
  logic                          v1;
  logic [sgtp_pkg::CODE_W-1:0]   code1;
  logic [sgtp_pkg::CODE_W-1:0]   code1_next;

  // stage 2: hit vector
  logic                              v2;
  logic [sgtp_pkg::CODE_W-1:0]       code2;
  logic [sgtp_pkg::RANGE_COUNT-1:0]  hit2;
  logic [sgtp_pkg::RANGE_COUNT-1:0]  hit2_next;

  // stage 3: selected range
  logic                          v3;
  logic [7:0]                    lo3;
  logic                          miss3;
  logic [sgtp_pkg::TILE_W-1:0]   tile0_3;
  logic [7:0]                    first_lo3;
  logic                          skips3;
  logic [sgtp_pkg::RANGE_IDX_W-1:0] sel;
  logic                          any_hit;

  // stage 4
  logic [7:0]                    delta;
  logic                          hole;
  sgtp_pkg::tile_word_t          word_next;

  always_comb begin
    code1_next = char_code;
    if (char_code == sgtp_pkg::REMAP_A_IN) begin
      code1_next = sgtp_pkg::REMAP_A_OUT;
    end else if (char_code == sgtp_pkg::REMAP_B_IN) begin
      code1_next = sgtp_pkg::REMAP_B_OUT;
    end else if (char_code == sgtp_pkg::REMAP_C_IN) begin
      code1_next = sgtp_pkg::REMAP_C_OUT;
    end else if (char_code == sgtp_pkg::REMAP_D_IN) begin
      code1_next = sgtp_pkg::REMAP_D_OUT;
    end else if (char_code >= sgtp_pkg::SHIFT_LO && char_code <= sgtp_pkg::SHIFT_HI) begin
      code1_next = char_code - sgtp_pkg::SHIFT_AMT;
    end
  end

  always_comb begin
    for (int i = 0; i < sgtp_pkg::RANGE_COUNT; i++) begin
      hit2_next[i] = (code1 >= sgtp_pkg::RANGES[i].first) &&
                     (code1 <= sgtp_pkg::RANGES[i].last);
    end
  end

  // lowest index hit wins
  always_comb begin
    sel     = '0;
    any_hit = |hit2;
    for (int i = sgtp_pkg::RANGE_COUNT - 1; i >= 0; i--) begin
      if (hit2[i]) begin
        sel = sgtp_pkg::RANGE_IDX_W'(i);
      end
    end
  end

  always_comb begin
    hole  = skips3 && (lo3 == sgtp_pkg::SKIP_LO);
    delta = lo3 - first_lo3;
    if (skips3 && (lo3 > sgtp_pkg::SKIP_LO)) begin
      delta = delta - 8'd1;
    end
    word_next.miss = miss3;
    word_next.tile = hole ? sgtp_pkg::HOLE_TILE
                          : tile0_3 + sgtp_pkg::TILE_W'(delta);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      tile_valid <= 1'b0;
    end else if (en) begin
      v1         <= in_valid;
      v2         <= v1;
      v3         <= v2;
      tile_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code1     <= code1_next;
      code2     <= code1;
      hit2      <= hit2_next;
      lo3       <= code2[7:0];
      miss3     <= !any_hit;
      tile0_3   <= sgtp_pkg::RANGES[sel].tile0;
      first_lo3 <= sgtp_pkg::RANGES[sel].first[7:0];
      skips3    <= sgtp_pkg::RANGES[sel].skips;
      tile_word <= word_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/sgtp_pos.sv
// Tile number to pixel position: reciprocal divide, remainder fix-up, scale.
`timescale 1ns / 1ps
`default_nettype none
module sgtp_pos #(
  parameter int GLYPH_WIDTH   = sgtp_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT  = sgtp_pkg::GLYPH_HEIGHT_DEF,
  parameter int TILES_PER_ROW = sgtp_pkg::TILES_PER_ROW_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        tile_valid,
  input  wire sgtp_pkg::tile_word_t        tile_word,
  output logic                             out_valid,
  output logic [sgtp_pkg::X_W-1:0]         x_pos,
  output logic [sgtp_pkg::Y_W-1:0]         y_pos
);

  localparam int TW        = sgtp_pkg::TILE_W;
  localparam int PW        = sgtp_pkg::PARAM_W;
  localparam int DW        = $clog2(TILES_PER_ROW + 1);
  localparam int DIV_SHIFT = TW + PW;
  localparam int MULT_W    = DIV_SHIFT + 1;
  localparam int QP_W      = TW + MULT_W;
  localparam logic [MULT_W-1:0] DIV_MULT =
    MULT_W'(((2 ** DIV_SHIFT) + TILES_PER_ROW - 1) / TILES_PER_ROW);
  localparam logic [TW-1:0] DIV_D = TW'(TILES_PER_ROW);
  localparam logic [PW-1:0] GW    = PW'(GLYPH_WIDTH);
  localparam logic [PW-1:0] GH    = PW'(GLYPH_HEIGHT);

  // stage 5: quotient estimate
  logic             v5;
  logic             miss5;
  logic [TW-1:0]    tile5;
  logic [TW-1:0]    q5;
  logic [QP_W-1:0]  qprod;

  // stage 6: exact row and column
  logic             v6;
  logic             miss6;
  logic [TW-1:0]    q6;
  logic [DW-1:0]    r6;
  logic [2*TW-1:0]  qd;
  logic [TW-1:0]    rem_raw;
  logic             fix;

  // stage 7 products
  logic [DW+PW-1:0] xprod;
  logic [TW+PW-1:0] yprod;

  assign qprod   = QP_W'(tile_word.tile) * QP_W'(DIV_MULT);
  assign qd      = (2*TW)'(q5) * (2*TW)'(DIV_D);
  assign rem_raw = tile5 - qd[TW-1:0];
  assign fix     = rem_raw >= DIV_D;
  assign xprod   = (DW+PW)'(r6) * (DW+PW)'(GW);
  assign yprod   = (TW+PW)'(q6) * (TW+PW)'(GH);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v5        <= tile_valid;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss5 <= tile_word.miss;
      tile5 <= tile_word.tile;
      q5    <= qprod[DIV_SHIFT +: TW];
      miss6 <= miss5;
      q6    <= fix ? q5 + TW'(1) : q5;
      r6    <= DW'(fix ? rem_raw - DIV_D : rem_raw);
      x_pos <= miss6 ? sgtp_pkg::MISS_X : xprod[sgtp_pkg::X_W-1:0];
      y_pos <= miss6 ? sgtp_pkg::MISS_Y : yprod[sgtp_pkg::Y_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/sjis_glyph_tile_position_core.sv
// A code runs through seven stage registers that advance together to the output.
// Throughput: one code per cycle while the output is not stalled.
// A stalled output word holds the whole pipe; in_stall follows out_stall only
// while the output stage holds a valid word, so bubbles drain freely.
// Reset (rst, synchronous) clears all stage valid bits; data registers are not reset.
// Top level: double-byte code to glyph pixel position in the font sheet.
`timescale 1ns / 1ps
`default_nettype none
module sjis_glyph_tile_position_core #(
  parameter int GLYPH_WIDTH   = sgtp_pkg::GLYPH_WIDTH_DEF,
  parameter int GLYPH_HEIGHT  = sgtp_pkg::GLYPH_HEIGHT_DEF,
  parameter int TILES_PER_ROW = sgtp_pkg::TILES_PER_ROW_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [sgtp_pkg::CODE_W-1:0]   char_code,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sgtp_pkg::X_W-1:0]           x_pos,
  output logic [sgtp_pkg::Y_W-1:0]           y_pos
);

  // Pipeline advance: only a valid word that the sink refuses holds the pipe.
  logic                 en;
  logic                 tile_valid;
  sgtp_pkg::tile_word_t tile_word;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stages 1-4: remap, range hit vector, first-hit select, tile number.
  sgtp_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .char_code  (char_code),
    .tile_valid (tile_valid),
    .tile_word  (tile_word)
  );

  // Stages 5-7: row/column split by reciprocal multiply, then pixel scaling.
  // Unmatched codes bypass the scaling with the fixed miss position.
  sgtp_pos #(
    .GLYPH_WIDTH   (GLYPH_WIDTH),
    .GLYPH_HEIGHT  (GLYPH_HEIGHT),
    .TILES_PER_ROW (TILES_PER_ROW)
  ) u_pos (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .tile_valid (tile_valid),
    .tile_word  (tile_word),
    .out_valid  (out_valid),
    .x_pos      (x_pos),
    .y_pos      (y_pos)
  );

endmodule
`default_nettype wire

>>> rtl/sgtp_checker.sv
// Port-level checks for the glyph tile position core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sgtp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [sgtp_pkg::CODE_W-1:0]   char_code,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [sgtp_pkg::X_W-1:0]      x_pos,
  input wire logic [sgtp_pkg::Y_W-1:0]      y_pos
);

  // output word held while refused
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(x_pos) && $stable(y_pos))
    else $error("output word changed while stalled");

  // input side only pushes back when a finished word is refused
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a refused output word");

  // a word accepted while the sink keeps out_stall low shows up at the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted code did not reach output in time");

  // nothing comes out right after reset
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sjis_glyph_tile_position_core sgtp_checker u_sgtp_checker (.*);
`default_nettype wire
